// ===== rtl/xccd_pkg.sv =====
// ---------------------------------------------------------------------------
// xccd_pkg: shared definitions of the xor checked command deframer
// Character codes, parse phases, result kinds and status codes, and the
// result queue sizing used by the deframer.
// ---------------------------------------------------------------------------
package xccd_pkg;

   // frames this long or longer, counted from the start mark through LF, are dropped
   localparam int MaxFrameLen     = 512;
   localparam int FrameCountWidth = $clog2(MaxFrameLen);

   // most result beats one input beat can cause, and the result queue depth
   localparam int MaxResults      = 5;
   localparam int QueueDepth      = 8;
   localparam int QueuePtrWidth   = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   // characters with a meaning in the frame syntax
   localparam logic [7:0] ChStart = 8'h21;
   localparam logic [7:0] ChStar  = 8'h2A;
   localparam logic [7:0] ChEq    = 8'h3D;
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChLf    = 8'h0A;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_BODY,
      PH_BODY_CR,
      PH_FIELD,
      PH_SKIP,
      PH_SKIP_CR
   } phase_type;

   typedef enum logic [1:0] {
      KIND_KEY,
      KIND_VALUE,
      KIND_END
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_UNCHECKED,
      ST_MISMATCH,
      ST_BADFIELD,
      ST_NOEQ,
      ST_DROPPED
   } status_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      status_type status;
   } item_type;

   // hex digit decode: bit 4 set when the character is a hex digit
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end
      return r;
   endfunction

endpackage

// ===== rtl/xor_checked_command_deframer_unit.sv =====
// ---------------------------------------------------------------------------
// xor_checked_command_deframer_unit: command frame deframer with xor check
// Splits '!' ... CR LF frames into key and value bytes and closes each frame
// with one frame-end beat carrying its status.
// ---------------------------------------------------------------------------
// Usage
//   req_*  : one received character per beat; req_tuser set means clear the
//            partial frame, the character is then ignored.
//   rsp_*  : key byte, value byte or frame-end beats; frame end has tlast set.
//   csr_*  : strict checksum field bit; the user must see that it is written only
//            while the block is idle, as the block itself does not enforce this.
// Throughput: one input beat per cycle while req_tready is high. Each input beat is
//   parsed combinationally and writes up to five result beats into an eight-entry
//   result queue that drains one beat per cycle while rsp_tready is high; req_tready
//   is high while at most three beats are queued. A beat that causes several results
//   (a lone CR sent out with the byte after it, or held checksum field bytes released
//   as key or value bytes) grows the queue, and once more than three beats are queued
//   the input waits. Result beats enter the queue in order, behind older beats.
// Stall: a stalled receiver fills the queue and then holds req_tready low;
//   no beat is lost.
// Reset: synchronous; the parser returns to hunting for '!', the queue
//   empties and the strict bit clears.
// ---------------------------------------------------------------------------
module xor_checked_command_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   // input characters
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] clear_request
   // result beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_byte, [10:8] frame_status, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] item_kind
   output logic        rsp_tlast,   // last_of_frame
   // configuration
   input  logic        csr_wr_en,
   input  logic        csr_wr_data  // strict_checksum_field
);
   import xccd_pkg::*;

   logic                       strict_ff;
   phase_type                  phase_ff, phase_in;
   logic [7:0]                 xor_ff, xor_in;
   logic [FrameCountWidth-1:0] fcnt_ff, fcnt_in;
   logic                       sep_ff, sep_in;
   logic                       star_ff, star_in;
   logic [7:0]                 held_ff [4];
   logic [7:0]                 held_in [4];
   logic [2:0]                 hcnt_ff, hcnt_in;
   logic [7:0]                 rsum_ff, rsum_in;

   item_type                   items [MaxResults];
   logic [2:0]                 n_items;

   item_type                   queue_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   head_ff, tail_ff;
   logic [QueueCountWidth-1:0] qcnt_ff;

   logic                       req_acc, rsp_acc;
   logic [7:0]                 b;

   assign b          = req_tdata;
   assign req_tready = (qcnt_ff <= QueueCountWidth'(QueueDepth - MaxResults));
   assign req_acc    = req_tvalid & req_tready;
   assign rsp_tvalid = (qcnt_ff != '0);
   assign rsp_acc    = rsp_tvalid & rsp_tready;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b0;
      end else if (csr_wr_en) begin
         strict_ff <= csr_wr_data;
      end
   end

   // parser: next state and result beats of one input beat
   always_comb begin
      logic       emit_cr;
      logic [2:0] flush_cnt;
      logic       do_body;
      logic       do_end;
      status_type end_status;
      logic       pend;
      logic [4:0] hx;
      kind_type   dkind;

      phase_in = phase_ff;
      xor_in   = xor_ff;
      fcnt_in  = fcnt_ff;
      sep_in   = sep_ff;
      star_in  = star_ff;
      held_in  = held_ff;
      hcnt_in  = hcnt_ff;
      rsum_in  = rsum_ff;
      n_items  = 3'd0;
      for (int i = 0; i < MaxResults; i++) begin
         items[i] = '{kind: KIND_KEY, data: 8'd0, status: ST_OK};
      end
      emit_cr    = 1'b0;
      flush_cnt  = 3'd0;
      do_body    = 1'b0;
      do_end     = 1'b0;
      end_status = ST_OK;
      dkind      = sep_ff ? KIND_VALUE : KIND_KEY;
      pend       = (hcnt_ff >= 3'd2) && (hcnt_ff <= 3'd4) &&
                   (held_ff[2'(hcnt_ff - 3'd1)] == ChCr);
      hx         = hex_decode(b);

      priority if (req_tuser) begin
         // clear: a frame in progress closes as dropped
         if (phase_ff != PH_HUNT) begin
            do_end     = 1'b1;
            end_status = ST_DROPPED;
         end
         phase_in = PH_HUNT;
         hcnt_in  = 3'd0;
      end else if (phase_ff == PH_HUNT) begin
         // hunting for the start mark
         if (b == ChStart) begin
            phase_in = PH_BODY;
            xor_in   = ChStart;
            fcnt_in  = FrameCountWidth'(1);
            sep_in   = 1'b0;
            star_in  = 1'b0;
            hcnt_in  = 3'd0;
            rsum_in  = 8'd0;
         end
      end else if (fcnt_ff >= FrameCountWidth'(MaxFrameLen - 1)) begin
         // overflow
         hcnt_in    = 3'd0;
         do_end     = 1'b1;
         end_status = ST_DROPPED;
      end else begin
         fcnt_in = fcnt_ff + FrameCountWidth'(1);
         unique case (phase_ff)
            PH_BODY: begin
               do_body = 1'b1;
            end
            PH_BODY_CR: begin
               if (b == ChLf) begin
                  do_end     = 1'b1;
                  end_status = sep_ff ? ST_UNCHECKED : ST_NOEQ;
               end else begin
                  if (!star_ff) begin
                     xor_in = xor_ff ^ ChCr;
                  end
                  emit_cr = 1'b1;
                  do_body = 1'b1;
               end
            end
            PH_FIELD: begin
               if (pend && b == ChLf) begin
                  if (hcnt_ff == 3'd4) begin
                     hcnt_in    = 3'd0;
                     do_end     = 1'b1;
                     end_status = (xor_ff != rsum_ff) ? ST_MISMATCH :
                                  (sep_ff ? ST_OK : ST_NOEQ);
                  end else if (strict_ff) begin
                     hcnt_in    = 3'd0;
                     do_end     = 1'b1;
                     end_status = ST_BADFIELD;
                  end else begin
                     flush_cnt  = hcnt_ff - 3'd1;
                     hcnt_in    = 3'd0;
                     do_end     = 1'b1;
                     end_status = sep_ff ? ST_UNCHECKED : ST_NOEQ;
                  end
               end else if (!pend && hcnt_ff != 3'd0 && hcnt_ff <= 3'd3 &&
                            (b == ChCr || (hcnt_ff < 3'd3 && hx[4]))) begin
                  // well formed so far: hold the character
                  held_in[2'(hcnt_ff)] = b;
                  hcnt_in              = hcnt_ff + 3'd1;
                  if (b != ChCr) begin
                     rsum_in = {rsum_ff[3:0], hx[3:0]};
                  end
               end else if (strict_ff) begin
                  // malformed field, strict: swallow up to CR LF
                  hcnt_in  = 3'd0;
                  phase_in = (b == ChCr) ? PH_SKIP_CR : PH_SKIP;
               end else begin
                  // malformed field, lenient: held bytes become body bytes
                  flush_cnt = hcnt_ff;
                  hcnt_in   = 3'd0;
                  do_body   = 1'b1;
               end
            end
            PH_SKIP: begin
               phase_in = (b == ChCr) ? PH_SKIP_CR : PH_SKIP;
            end
            PH_SKIP_CR: begin
               if (b == ChLf) begin
                  do_end     = 1'b1;
                  end_status = ST_BADFIELD;
               end else begin
                  phase_in = (b == ChCr) ? PH_SKIP_CR : PH_SKIP;
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end

      // pending lone CR
      if (emit_cr) begin
         items[n_items] = '{kind: dkind, data: ChCr, status: ST_OK};
         n_items        = n_items + 3'd1;
      end

      // release held checksum field bytes
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < flush_cnt) begin
            items[n_items] = '{kind: dkind, data: held_ff[i], status: ST_OK};
            n_items        = n_items + 3'd1;
         end
      end

      // ordinary body byte
      if (do_body) begin
         phase_in = PH_BODY;
         if (b == ChCr) begin
            phase_in = PH_BODY_CR;
         end else if (b == ChStar && !star_in) begin
            star_in    = 1'b1;
            held_in[0] = b;
            hcnt_in    = 3'd1;
            rsum_in    = 8'd0;
            phase_in   = PH_FIELD;
         end else begin
            if (!star_in) begin
               xor_in = xor_in ^ b;
            end
            if (b == ChEq && !sep_ff) begin
               sep_in = 1'b1;
            end else begin
               items[n_items] = '{kind: dkind, data: b, status: ST_OK};
               n_items        = n_items + 3'd1;
            end
         end
      end

      // frame end
      if (do_end) begin
         phase_in       = PH_HUNT;
         items[n_items] = '{kind: KIND_END, data: 8'd0, status: end_status};
         n_items        = n_items + 3'd1;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         xor_ff   <= 8'd0;
         fcnt_ff  <= '0;
         sep_ff   <= 1'b0;
         star_ff  <= 1'b0;
         hcnt_ff  <= 3'd0;
         rsum_ff  <= 8'd0;
      end else if (req_acc) begin
         phase_ff <= phase_in;
         xor_ff   <= xor_in;
         fcnt_ff  <= fcnt_in;
         sep_ff   <= sep_in;
         star_ff  <= star_in;
         hcnt_ff  <= hcnt_in;
         rsum_ff  <= rsum_in;
      end
   end

   // held checksum field bytes
   always_ff @(posedge clock) begin
      if (req_acc) begin
         held_ff <= held_in;
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (req_acc) begin
         for (int k = 0; k < MaxResults; k++) begin
            if (3'(k) < n_items) begin
               queue_ff[tail_ff + QueuePtrWidth'(k)] <= items[k];
            end
         end
      end
   end

   // result queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         qcnt_ff <= '0;
      end else begin
         if (req_acc) begin
            tail_ff <= tail_ff + QueuePtrWidth'(n_items);
         end
         if (rsp_acc) begin
            head_ff <= head_ff + QueuePtrWidth'(1);
         end
         qcnt_ff <= qcnt_ff + (req_acc ? QueueCountWidth'(n_items) : '0)
                    - (rsp_acc ? QueueCountWidth'(1) : '0);
      end
   end

   // result beat
   assign rsp_tdata = {5'd0, queue_ff[head_ff].status, queue_ff[head_ff].data};
   assign rsp_tuser = queue_ff[head_ff].kind;
   assign rsp_tlast = (queue_ff[head_ff].kind == KIND_END);

   // checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff <= QueueCountWidth'(QueueDepth))
      else $error("result queue count beyond its depth");

   a_clear_hunts: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tuser |=> phase_ff == PH_HUNT && hcnt_ff == 3'd0)
      else $error("clear did not return the parser to hunting");

   a_clear_closes: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tuser && phase_ff != PH_HUNT && !rsp_acc
      |=> qcnt_ff == $past(qcnt_ff) + QueueCountWidth'(1))
      else $error("clear inside a frame did not queue one frame end");

   a_field_star: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_FIELD |-> star_ff && hcnt_ff != 3'd0 && hcnt_ff <= 3'd4)
      else $error("checksum field phase without a held star");

endmodule
